[src/rhc_pkg.sv]
// Shared types, constants and tables of the RGB to HSV converter.
package rhc_pkg;

  localparam int IN_SCALE  = 100;
  localparam int SAT_SCALE = 100;
  localparam int VAL_SCALE = 100;

  localparam int CH_W    = 7;
  localparam int HUE_W   = 9;
  localparam int NUM_W   = 16;
  localparam int LUT_LEN = 1 << CH_W;

  // Three restoring steps per divider stage, three stages cover the nine quotient bits.
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = HUE_W / STEPS_PER_STAGE;

  localparam logic [CH_W:0]  IN_SCALE_W  = (CH_W + 1)'(IN_SCALE);
  localparam logic [CH_W:0]  SAT_SCALE_W = (CH_W + 1)'(SAT_SCALE);
  localparam logic [NUM_W:0] DEG_60      = (NUM_W + 1)'(60);
  localparam logic [NUM_W:0] DEG_120     = (NUM_W + 1)'(120);
  localparam logic [NUM_W:0] DEG_240     = (NUM_W + 1)'(240);
  localparam logic [NUM_W:0] DEG_360     = (NUM_W + 1)'(360);
  localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(360);

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef logic [CH_W-1:0] val_lut_t [LUT_LEN];

  function automatic val_lut_t build_val_lut();
    val_lut_t lut;
    for (int i = 0; i < LUT_LEN; i++) begin
      lut[i] = CH_W'((i * VAL_SCALE) / IN_SCALE);
    end
    return lut;
  endfunction

  localparam val_lut_t VAL_LUT = build_val_lut();

  // One division in flight: partial remainder, and numerator bits that turn into quotient bits.
  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [HUE_W-1:0] acc;
    logic [CH_W-1:0]  den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t       hue_lane;
    div_lane_t       sat_lane;
    logic            grey;
    logic [CH_W-1:0] val;
  } pipe_t;

endpackage

[src/rhc_front.sv]
// Front end: clamp, max/min and sector, then difference and division operands.
module rhc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rhc_pkg::CH_W-1:0] red,
  input  logic [rhc_pkg::CH_W-1:0] green,
  input  logic [rhc_pkg::CH_W-1:0] blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rhc_pkg::pipe_t           out_data
);

  logic [rhc_pkg::CH_W-1:0] r_c, g_c, b_c, mx_c, mn_c;
  rhc_pkg::sector_t         sect_c;

  logic                     v0;
  logic [rhc_pkg::CH_W-1:0] r0, g0, b0, mx0, mn0;
  rhc_pkg::sector_t         sect0;
  logic                     adv0, adv1;

  logic [rhc_pkg::CH_W-1:0]  d_c;
  logic [rhc_pkg::NUM_W:0]   hnum_c, snum_c;
  rhc_pkg::pipe_t            data_next;

  function automatic logic [rhc_pkg::CH_W-1:0] clamp(input logic [rhc_pkg::CH_W-1:0] x);
    logic [rhc_pkg::CH_W-1:0] y;
    y = ({1'b0, x} > rhc_pkg::IN_SCALE_W) ? rhc_pkg::IN_SCALE_W[rhc_pkg::CH_W-1:0] : x;
    return y;
  endfunction

  assign adv1     = !out_valid || out_ready;
  assign adv0     = !v0 || adv1;
  assign in_ready = adv0;

  always_comb begin
    r_c = clamp(red);
    g_c = clamp(green);
    b_c = clamp(blue);
    if (r_c >= g_c && r_c >= b_c) begin
      sect_c = rhc_pkg::SECT_RED;
      mx_c   = r_c;
    end else if (g_c >= b_c) begin
      sect_c = rhc_pkg::SECT_GREEN;
      mx_c   = g_c;
    end else begin
      sect_c = rhc_pkg::SECT_BLUE;
      mx_c   = b_c;
    end
    mn_c = r_c;
    if (g_c < mn_c) mn_c = g_c;
    if (b_c < mn_c) mn_c = b_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      r0    <= r_c;
      g0    <= g_c;
      b0    <= b_c;
      mx0   <= mx_c;
      mn0   <= mn_c;
      sect0 <= sect_c;
    end
  end

  // Hue numerators below are non-negative and stay below 512 * d.
  always_comb begin
    d_c = mx0 - mn0;
    case (sect0)
      rhc_pkg::SECT_RED: begin
        if (g0 >= b0) begin
          hnum_c = rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(g0 - b0);
        end else begin
          hnum_c = rhc_pkg::DEG_360 * (rhc_pkg::NUM_W + 1)'(d_c)
                 - rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(b0 - g0);
        end
      end
      rhc_pkg::SECT_GREEN: begin
        hnum_c = rhc_pkg::DEG_120 * (rhc_pkg::NUM_W + 1)'(d_c)
               + rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(b0)
               - rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(r0);
      end
      rhc_pkg::SECT_BLUE: begin
        hnum_c = rhc_pkg::DEG_240 * (rhc_pkg::NUM_W + 1)'(d_c)
               + rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(r0)
               - rhc_pkg::DEG_60 * (rhc_pkg::NUM_W + 1)'(g0);
      end
      default: begin
        hnum_c = '0;
      end
    endcase
    snum_c = (rhc_pkg::NUM_W + 1)'(d_c) * (rhc_pkg::NUM_W + 1)'(rhc_pkg::SAT_SCALE_W);

    data_next.hue_lane.rem = hnum_c[rhc_pkg::NUM_W-1:rhc_pkg::HUE_W];
    data_next.hue_lane.acc = hnum_c[rhc_pkg::HUE_W-1:0];
    data_next.hue_lane.den = d_c;
    data_next.sat_lane.rem = snum_c[rhc_pkg::NUM_W-1:rhc_pkg::HUE_W];
    data_next.sat_lane.acc = snum_c[rhc_pkg::HUE_W-1:0];
    data_next.sat_lane.den = mx0;
    data_next.grey         = (d_c == '0);
    data_next.val          = rhc_pkg::VAL_LUT[mx0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1) begin
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v0) begin
      out_data <= data_next;
    end
  end

endmodule

[src/rhc_div_stage.sv]
// One divider stage: STEPS_PER_STAGE restoring division steps on the hue and saturation lanes.
module rhc_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rhc_pkg::pipe_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rhc_pkg::pipe_t out_data
);

  rhc_pkg::pipe_t data_next;

  function automatic rhc_pkg::div_lane_t div_step(input rhc_pkg::div_lane_t l);
    rhc_pkg::div_lane_t       o;
    logic [rhc_pkg::CH_W:0]   part;
    logic                     ge;
    part  = {l.rem, l.acc[rhc_pkg::HUE_W-1]};
    ge    = (part >= {1'b0, l.den});
    o.den = l.den;
    o.acc = {l.acc[rhc_pkg::HUE_W-2:0], ge};
    o.rem = ge ? rhc_pkg::CH_W'(part - {1'b0, l.den}) : part[rhc_pkg::CH_W-1:0];
    return o;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < rhc_pkg::STEPS_PER_STAGE; i++) begin
      data_next.hue_lane = div_step(data_next.hue_lane);
      data_next.sat_lane = div_step(data_next.sat_lane);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[src/rgb_to_hsv_convert_unit.sv]
// Top level of the RGB to HSV converter: front end and pipelined divider.
//
// Input channel: color_valid / color_ready carry one item of red, green and
// blue, each 0..100 (larger codes clamp to 100). Output channel:
// hsv_valid / hsv_ready carry hue (0..359 degrees), saturation and
// brightness (0..100), all truncated toward zero.
//
// Five register stages: two front stages (clamp, max/min and sector; then
// difference and numerators), then three divider stages of three restoring
// steps each for the nine quotient bits; hsv_valid is the last stage's valid
// bit. Throughput: one item per cycle while hsv_ready is high. Every stage
// has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles collapse.
//
// Reset (rst, synchronous) clears all valid bits; data registers are not
// reset. When the receiver holds hsv_ready low, the last stage holds its
// item and earlier stages keep filling; color_ready drops only once all
// five stages hold items. Nothing is dropped or repeated across a stall.
// Black and grey inputs (max equals min) force hue and saturation to zero.
module rgb_to_hsv_convert_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      color_valid,
  output logic                      color_ready,
  input  logic [rhc_pkg::CH_W-1:0]  red,
  input  logic [rhc_pkg::CH_W-1:0]  green,
  input  logic [rhc_pkg::CH_W-1:0]  blue,
  output logic                      hsv_valid,
  input  logic                      hsv_ready,
  output logic [rhc_pkg::HUE_W-1:0] hue,
  output logic [rhc_pkg::CH_W-1:0]  saturation,
  output logic [rhc_pkg::CH_W-1:0]  brightness
);

  localparam int N = rhc_pkg::DIV_STAGES;

  logic           stg_valid [N+1];
  logic           stg_ready [N+1];
  rhc_pkg::pipe_t stg_data  [N+1];

  // Front end feeds slot 0 of the divider chain.
  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (color_valid),
    .in_ready  (color_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar s = 0; s < N; s++) begin : g_div
    rhc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[s]),
      .in_ready  (stg_ready[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_ready (stg_ready[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  assign stg_ready[N] = hsv_ready;
  assign hsv_valid    = stg_valid[N];

  // Drop the quotients of grey and black items; the hue divisor there is zero.
  assign hue        = stg_data[N].grey ? '0 : stg_data[N].hue_lane.acc;
  assign saturation = stg_data[N].grey ? '0 : stg_data[N].sat_lane.acc[rhc_pkg::CH_W-1:0];
  assign brightness = stg_data[N].val;

endmodule

[src/rhc_checker.sv]
// Port-level checks of the RGB to HSV converter, bound to the top level.
module rhc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      hsv_valid,
  input logic                      hsv_ready,
  input logic [rhc_pkg::HUE_W-1:0] hue,
  input logic [rhc_pkg::CH_W-1:0]  saturation,
  input logic [rhc_pkg::CH_W-1:0]  brightness
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !hsv_valid)
    else $error("result shown right after reset");

  a_hold_stalled : assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) && $stable(saturation)
                               && $stable(brightness))
    else $error("stalled result changed or vanished");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hue < rhc_pkg::HUE_LIMIT)
    else $error("hue beyond 359");

  a_sat_range : assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> {1'b0, saturation} <= rhc_pkg::SAT_SCALE_W)
    else $error("saturation beyond scale");

endmodule

bind rgb_to_hsv_convert_unit rhc_checker u_rhc_checker (.*);

[test/rgb_to_hsv_convert_unit_test.sv]
// Self-checking testbench of the RGB to HSV converter: directed corners, random colors, stalls.
module rgb_to_hsv_convert_unit_test;

  typedef struct packed {
    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::CH_W-1:0]  sat;
    logic [rhc_pkg::CH_W-1:0]  val;
  } hsv_t;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 12;    // idle cycles after the last expected result is back

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      color_valid = 1'b0;
  logic                      color_ready;
  logic [rhc_pkg::CH_W-1:0]  red         = '0;
  logic [rhc_pkg::CH_W-1:0]  green       = '0;
  logic [rhc_pkg::CH_W-1:0]  blue        = '0;
  logic                      hsv_valid;
  logic                      hsv_ready   = 1'b0;
  logic [rhc_pkg::HUE_W-1:0] hue;
  logic [rhc_pkg::CH_W-1:0]  saturation;
  logic [rhc_pkg::CH_W-1:0]  brightness;

  hsv_t expected_hsv[$];
  int   mismatch_count  = 0;
  int   colors_sent     = 0;
  int   results_checked = 0;
  int   idle_cycles     = 0;
  int   hold_cycles     = 0;     // long output hold-off, carried out by the sink process
  bit   src_gaps        = 1'b0;
  bit   sink_stalls     = 1'b1;

  rgb_to_hsv_convert_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .color_valid(color_valid),
    .color_ready(color_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_ready  (hsv_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always #10 clk = ~clk;

  // Exact integer conversion; every quotient is non-negative and truncates.
  function automatic hsv_t predict_hsv(input logic [rhc_pkg::CH_W-1:0] r_in, g_in, b_in);
    int               r, g, b, mx, mn, d;
    rhc_pkg::sector_t sect;
    hsv_t             res;
    r = (r_in > rhc_pkg::IN_SCALE) ? rhc_pkg::IN_SCALE : int'(r_in);
    g = (g_in > rhc_pkg::IN_SCALE) ? rhc_pkg::IN_SCALE : int'(g_in);
    b = (b_in > rhc_pkg::IN_SCALE) ? rhc_pkg::IN_SCALE : int'(b_in);
    // Strict compares: red wins ties, then green.
    mx   = r;
    sect = rhc_pkg::SECT_RED;
    if (g > mx) begin
      mx   = g;
      sect = rhc_pkg::SECT_GREEN;
    end
    if (b > mx) begin
      mx   = b;
      sect = rhc_pkg::SECT_BLUE;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    res = '0;
    res.val = rhc_pkg::CH_W'((mx * rhc_pkg::VAL_SCALE) / rhc_pkg::IN_SCALE);
    // Black and grey leave hue and saturation at zero.
    if (mx != 0 && d != 0) begin
      res.sat = rhc_pkg::CH_W'((d * rhc_pkg::SAT_SCALE) / mx);
      case (sect)
        rhc_pkg::SECT_RED: begin
          if (g >= b) res.hue = rhc_pkg::HUE_W'((60 * (g - b)) / d);
          else        res.hue = rhc_pkg::HUE_W'((360 * d - 60 * (b - g)) / d);
        end
        rhc_pkg::SECT_GREEN: res.hue = rhc_pkg::HUE_W'((120 * d + 60 * b - 60 * r) / d);
        default:             res.hue = rhc_pkg::HUE_W'((240 * d + 60 * r - 60 * g) / d);
      endcase
    end
    return res;
  endfunction

  // Channels mostly in range, some above scale to exercise the clamp.
  function automatic logic [rhc_pkg::CH_W-1:0] pick_channel();
    if ($urandom_range(0, 6) == 0) begin
      return rhc_pkg::CH_W'($urandom_range(0, (1 << rhc_pkg::CH_W) - 1));
    end
    return rhc_pkg::CH_W'($urandom_range(0, rhc_pkg::IN_SCALE));
  endfunction

  task automatic pick_color(output logic [rhc_pkg::CH_W-1:0] r, g, b);
    r = pick_channel();
    g = pick_channel();
    b = pick_channel();
    // Force ties and greys now and then; they steer the sector choice.
    case ($urandom_range(0, 9))
      0: g = r;
      1: b = g;
      2: b = r;
      3: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
  endtask

  // Offer one color and hold it until the converter takes it.
  task automatic send_color(input logic [rhc_pkg::CH_W-1:0] r, g, b);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      color_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    color_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (!color_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [rhc_pkg::CH_W-1:0] r, g, b;
    repeat (count) begin
      pick_color(r, g, b);
      send_color(r, g, b);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_hsv.size() != 0);
  endtask

  // Output side: random stall bursts, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hsv_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        hsv_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        hsv_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        hsv_ready <= 1'b1;
      end else begin
        hsv_ready <= 1'b1;
      end
    end
  end

  // Record each accepted color and compare each accepted result in order.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (hsv_valid && hsv_ready) begin
        if (expected_hsv.size() == 0) begin
          $error("result with none expected: hue=%0d saturation=%0d brightness=%0d",
                 hue, saturation, brightness);
          mismatch_count++;
        end else begin
          want = expected_hsv.pop_front();
          results_checked++;
          if (hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, hue);
            mismatch_count++;
          end
          if (saturation !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, saturation);
            mismatch_count++;
          end
          if (brightness !== want.val) begin
            $error("brightness: expected %0d, got %0d", want.val, brightness);
            mismatch_count++;
          end
        end
      end
      if (color_valid && color_ready) begin
        expected_hsv.push_back(predict_hsv(red, green, blue));
        colors_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (color_valid && color_ready) || (hsv_valid && hsv_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_hsv.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_corner_colors();
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    send_color(7'd0,   7'd0,   7'd0);    // black
    send_color(7'd100, 7'd100, 7'd100);  // full white
    send_color(7'd50,  7'd50,  7'd50);   // grey
    send_color(7'd127, 7'd127, 7'd127);  // all above scale, clamps to white
    send_color(7'd100, 7'd0,   7'd0);    // pure primaries
    send_color(7'd0,   7'd100, 7'd0);
    send_color(7'd0,   7'd0,   7'd100);
    send_color(7'd100, 7'd0,   7'd1);    // red largest, hue wraps below 360
    send_color(7'd100, 7'd100, 7'd0);    // red and green tie
    send_color(7'd0,   7'd100, 7'd100);  // green and blue tie
    send_color(7'd100, 7'd0,   7'd100);  // red and blue tie
    send_color(7'd1,   7'd0,   7'd0);    // smallest nonzero
    send_color(7'd127, 7'd0,   7'd0);    // clamp on red
    send_color(7'd0,   7'd127, 7'd64);   // clamp on green
    send_color(7'd101, 7'd50,  7'd0);    // one past scale
    send_color(7'd0,   7'd1,   7'd100);
    send_color(7'd1,   7'd2,   7'd3);
    send_color(7'd99,  7'd100, 7'd98);
    send_color(7'd64,  7'd32,  7'd16);
    send_color(7'd127, 7'd0,   7'd127);
    send_color(7'd63,  7'd127, 7'd0);
  endtask

  task automatic test_random_colors();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_random(700);
  endtask

  // Hold the output long enough for the pipeline to fill and stall the input.
  task automatic test_output_hold_off();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_cycles = 80;
    send_random(40);
  endtask

  // Stop offering until every result is back, then resume.
  task automatic test_drain_pauses();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (5) begin
      send_random(30);
      color_valid <= 1'b0;
      wait_drained();
    end
  endtask

  task automatic test_full_rate();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_random(400);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_colors();
    test_random_colors();
    test_output_hold_off();
    test_drain_pauses();
    test_full_rate();

    color_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d colors in, %0d results compared", colors_sent, results_checked);
    $display("phases: corners, random with gaps, long output hold-off, drain pauses, full rate");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_div_stage.sv
src/rgb_to_hsv_convert_unit.sv
src/rhc_checker.sv
test/rgb_to_hsv_convert_unit_test.sv
